[rtl/sfdm_pkg.sv]
// Package for the signed floor divide and modulo block.
// Holds the data width, the operation codes and the pipeline stage records.
// No dependencies; every other file of the block refers to it by scoped names.
package sfdm_pkg;

  localparam int Width = 64;

  typedef enum logic {
    OP_QUOT = 1'b0,
    OP_REM  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              neg_q;
    logic              sign_b;
    logic              zero_div;
    logic [Width-1:0]  dvs;
    logic [Width-1:0]  rem;
    logic [Width-1:0]  quo;
  } div_state_t;

  typedef struct packed {
    logic              neg;
    logic              zero;
    logic [Width-1:0]  mag;
  } post_t;

endpackage

[rtl/sfdm_req_if.sv]
// Request channel of the signed floor divide and modulo block.
// Carries valid, ready, the operation select and both operands.
// Depends on sfdm_pkg for the data width.
interface sfdm_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic signed [sfdm_pkg::Width-1:0] dividend;
  logic signed [sfdm_pkg::Width-1:0] divisor;

  modport source (output valid, req_type, dividend, divisor, input ready);
  modport sink (input valid, req_type, dividend, divisor, output ready);
endinterface

[rtl/sfdm_rsp_if.sv]
// Response channel of the signed floor divide and modulo block.
// Carries valid, ready and the signed result.
// Depends on sfdm_pkg for the data width.
interface sfdm_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [sfdm_pkg::Width-1:0] result;

  modport source (output valid, result, input ready);
  modport sink (input valid, result, output ready);
endinterface

[rtl/sfdm_div_stage.sv]
// One restoring division step with its pipeline register.
// Produces one quotient bit per stage; depends on sfdm_pkg for the stage record.
module sfdm_div_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  sfdm_pkg::div_state_t    in_state,
  output logic                    valid,
  output sfdm_pkg::div_state_t    state
);

  logic [sfdm_pkg::Width:0]   shifted;
  logic [sfdm_pkg::Width:0]   diff;
  logic                       take;
  sfdm_pkg::div_state_t       state_next;

  always_comb begin
    shifted    = {in_state.rem, in_state.quo[sfdm_pkg::Width-1]};
    diff       = shifted - {1'b0, in_state.dvs};
    take       = ~diff[sfdm_pkg::Width];
    state_next = in_state;
    state_next.rem = take ? diff[sfdm_pkg::Width-1:0] : shifted[sfdm_pkg::Width-1:0];
    state_next.quo = {in_state.quo[sfdm_pkg::Width-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state <= state_next;
    end
  end

  // The partial remainder stays below the divisor magnitude whenever the divisor is nonzero.
  a_rem_below_dvs: assert property (@(posedge clk) disable iff (rst)
    valid && !state.zero_div |-> state.rem < state.dvs)
    else $error("partial remainder not below divisor");

endmodule

[rtl/signed_floor_divide_modulo.sv]
// Top level of the signed floor divide and modulo block.
// Depends on sfdm_pkg, sfdm_req_if, sfdm_rsp_if and sfdm_div_stage.
//
// Usage: each transfer on the req channel carries req_type (0 floor quotient,
// 1 floor remainder) and two signed 64-bit operands. Each request yields one
// transfer on the rsp channel carrying the signed 64-bit result, in order.
// The quotient rounds toward negative infinity and the remainder takes the
// sign of the divisor. A zero divisor gives zero for both operations.
// From the request transfer to rsp.valid, a request passes the operand
// magnitude register, 64 restoring stages of one quotient bit each, the sign
// correction register and the output register. One request is accepted every
// cycle while req.ready is high. The whole pipeline advances together;
// req.ready is low only while a result waits in the output register and
// rsp.ready is low, and then every stage holds its contents. Synchronous
// reset clears all valid bits; results in flight are dropped.
module signed_floor_divide_modulo (
  input  logic       clk,
  input  logic       rst,
  sfdm_req_if.sink   req,
  sfdm_rsp_if.source rsp
);

  localparam int W = sfdm_pkg::Width;

  logic                   en;
  logic                   st_valid [0:W];
  sfdm_pkg::div_state_t   st       [0:W];
  logic                   pre_valid;
  sfdm_pkg::div_state_t   pre;
  sfdm_pkg::div_state_t   pre_next;
  logic [W-1:0]           abs_a;
  logic [W-1:0]           abs_b;
  logic                   post_valid;
  sfdm_pkg::post_t        post_q;
  sfdm_pkg::post_t        post_next;
  logic                   adj;
  logic [W-1:0]           result_next;

  assign en        = ~rsp.valid | rsp.ready;
  assign req.ready = en;

  always_comb begin
    abs_a = req.dividend[W-1] ? W'(-req.dividend) : W'(req.dividend);
    abs_b = req.divisor[W-1] ? W'(-req.divisor) : W'(req.divisor);
    pre_next.op       = sfdm_pkg::op_t'(req.req_type);
    pre_next.neg_q    = req.dividend[W-1] ^ req.divisor[W-1];
    pre_next.sign_b   = req.divisor[W-1];
    pre_next.zero_div = (req.divisor == '0);
    pre_next.dvs      = abs_b;
    pre_next.rem      = '0;
    pre_next.quo      = abs_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
    end else if (en) begin
      pre_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre <= pre_next;
    end
  end

  assign st_valid[0] = pre_valid;
  assign st[0]       = pre;

  for (genvar i = 0; i < W; i++) begin : g_div
    sfdm_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (st_valid[i]),
      .in_state (st[i]),
      .valid    (st_valid[i+1]),
      .state    (st[i+1])
    );
  end

  always_comb begin
    adj            = st[W].neg_q & (st[W].rem != '0);
    post_next.zero = st[W].zero_div;
    case (st[W].op)
      sfdm_pkg::OP_QUOT: begin
        post_next.neg = st[W].neg_q;
        post_next.mag = st[W].quo + W'(adj);
      end
      sfdm_pkg::OP_REM: begin
        post_next.neg = st[W].sign_b;
        post_next.mag = adj ? st[W].dvs - st[W].rem : st[W].rem;
      end
      default: begin
        post_next.neg = 1'b0;
        post_next.mag = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      post_valid <= 1'b0;
    end else if (en) begin
      post_valid <= st_valid[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      post_q <= post_next;
    end
  end

  always_comb begin
    if (post_q.zero) begin
      result_next = '0;
    end else if (post_q.neg) begin
      result_next = '0 - post_q.mag;
    end else begin
      result_next = post_q.mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= post_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.result <= result_next;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp.valid)
    else $error("output valid right after reset");

  a_zero_div_result: assert property (@(posedge clk) disable iff (rst)
    post_valid && post_q.zero && en |=> rsp.result == '0)
    else $error("zero divisor gave a nonzero result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(post_valid) && $stable(st_valid[W]) && $stable(st_valid[0]))
    else $error("pipeline moved during a stall");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    st_valid[W] && en |=> post_valid)
    else $error("item lost between division and correction stages");

endmodule
